[hdl/mlsng_pkg.sv]
// ============================================================================
// MLS noise generator package
// Shared constants, code types and the primitive polynomial taps table.
// ============================================================================
package mlsng_pkg;

    localparam int MAX_BITS  = 64;
    localparam int LEN_W     = 7;
    localparam int POS_W     = 6;
    localparam int SAMPLE_W  = 24;
    localparam int FRAC_BITS = 20;
    localparam int NOISE_W   = SAMPLE_W + 1;
    localparam int SUM_W     = SAMPLE_W + 2;
    localparam int PROD_W    = SAMPLE_W + NOISE_W;
    localparam int MAG_W     = PROD_W + 1 - FRAC_BITS;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_BITS);

    localparam logic signed [SAMPLE_W-1:0] AMP_RESET = SAMPLE_W'(1048576);
    localparam logic signed [SAMPLE_W-1:0] OFS_RESET = '0;

    localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ADD   = 2'd1,
        OP_MUL   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH    = 2'd0,
        CFG_AMPLITUDE = 2'd1,
        CFG_OFFSET    = 2'd2
    } t_cfg_reg;

    // Mask with the lowest n bits set.
    function automatic logic [MAX_BITS-1:0] width_mask(input logic [LEN_W-1:0] n);
        logic [MAX_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_BITS; i++) begin
            m[i] = (LEN_W'(i) < n);
        end
        return m;
    endfunction

    // Feedback taps for an LFSR of length idx + 1.
    function automatic logic [MAX_BITS-1:0] taps_rom(input logic [POS_W-1:0] idx);
        logic [MAX_BITS-1:0] t;
        case (idx)
            6'd0:  t = 64'd1;
            6'd1:  t = 64'd3;
            6'd2:  t = 64'd3;
            6'd3:  t = 64'd3;
            6'd4:  t = 64'd5;
            6'd5:  t = 64'd3;
            6'd6:  t = 64'd3;
            6'd7:  t = 64'd99;
            6'd8:  t = 64'd17;
            6'd9:  t = 64'd9;
            6'd10: t = 64'd5;
            6'd11: t = 64'd153;
            6'd12: t = 64'd27;
            6'd13: t = 64'd6147;
            6'd14: t = 64'd3;
            6'd15: t = 64'd45;
            6'd16: t = 64'd9;
            6'd17: t = 64'd129;
            6'd18: t = 64'd99;
            6'd19: t = 64'd9;
            6'd20: t = 64'd5;
            6'd21: t = 64'd3;
            6'd22: t = 64'd33;
            6'd23: t = 64'd27;
            6'd24: t = 64'd9;
            6'd25: t = 64'd387;
            6'd26: t = 64'd387;
            6'd27: t = 64'd9;
            6'd28: t = 64'd5;
            6'd29: t = 64'd98307;
            6'd30: t = 64'd9;
            6'd31: t = 64'd402653187;
            6'd32: t = 64'd8193;
            6'd33: t = 64'd49155;
            6'd34: t = 64'd5;
            6'd35: t = 64'd2049;
            6'd36: t = 64'd5125;
            6'd37: t = 64'd99;
            6'd38: t = 64'd17;
            6'd39: t = 64'd2621445;
            6'd40: t = 64'd9;
            6'd41: t = 64'd12582915;
            6'd42: t = 64'd99;
            6'd43: t = 64'd201326595;
            6'd44: t = 64'd27;
            6'd45: t = 64'd3145731;
            6'd46: t = 64'd33;
            6'd47: t = 64'd402653187;
            6'd48: t = 64'd513;
            6'd49: t = 64'd201326595;
            6'd50: t = 64'd98307;
            6'd51: t = 64'd9;
            6'd52: t = 64'd98307;
            6'd53: t = 64'd206158430211;
            6'd54: t = 64'd16777217;
            6'd55: t = 64'd6291459;
            6'd56: t = 64'd129;
            6'd57: t = 64'd524289;
            6'd58: t = 64'd6291459;
            6'd59: t = 64'd3;
            6'd60: t = 64'd98307;
            6'd61: t = 64'd216172782113783811;
            6'd62: t = 64'd3;
            6'd63: t = 64'd27;
            default: t = 64'd1;
        endcase
        return t;
    endfunction

endpackage

[hdl/mls_noise_generator.sv]
// ============================================================================
// MLS noise generator
// Fibonacci LFSR noise source that writes, adds or multiplies noise samples.
// ============================================================================
// Usage:
//   Slave channel: one beat per sample. tdata carries the Q4.20 input sample,
//   tuser the operation (overwrite, add, multiply) and tlast the block end.
//   Master channel: one beat per input beat. tdata carries the saturated
//   Q4.20 result, tuser the sequence bit used for it and tlast the copy of
//   the block end flag.
//   An accepted input beat passes an input stage that shifts the LFSR and
//   forms the noise value, a stage holding the sum or the registered
//   24 x 25 bit product, and the output register that rounds and
//   saturates. Throughput is one beat per cycle while the receiver is ready.
//   The configuration port sets the LFSR length (1 to 64, clamped), the
//   amplitude and the offset; write it only while no beat is in flight.
//   Reset sets length 64, amplitude 1.0, offset 0 and an all-ones state.
//   When the receiver stalls, each stage holds its beat; empty stages ahead
//   still fill, so the input keeps taking beats until the pipeline is full.
// ============================================================================
module mls_noise_generator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port
    input  logic                                  i_cfg_we,
    input  logic [mlsng_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mlsng_pkg::SAMPLE_W-1:0]        i_cfg_data,
    // Slave channel
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [mlsng_pkg::SAMPLE_W-1:0]        i_s_tdata,  // [23:0] input_sample
    input  logic [1:0]                            i_s_tuser,  // [1:0] operation
    input  logic                                  i_s_tlast,  // block_end
    // Master channel
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [mlsng_pkg::SAMPLE_W-1:0]        o_m_tdata,  // [23:0] output_sample
    output logic                                  o_m_tuser,  // [0] sequence_bit
    output logic                                  o_m_tlast   // block_end_out
);

    localparam int MAX_BITS = mlsng_pkg::MAX_BITS;
    localparam int LEN_W    = mlsng_pkg::LEN_W;
    localparam int POS_W    = mlsng_pkg::POS_W;
    localparam int SAMPLE_W = mlsng_pkg::SAMPLE_W;
    localparam int NOISE_W  = mlsng_pkg::NOISE_W;
    localparam int SUM_W    = mlsng_pkg::SUM_W;
    localparam int PROD_W   = mlsng_pkg::PROD_W;
    localparam int MAG_W    = mlsng_pkg::MAG_W;

    // Configuration and LFSR state
    logic [MAX_BITS-1:0]        r_lfsr, n_lfsr;
    logic [MAX_BITS-1:0]        r_mask, n_mask;
    logic [MAX_BITS-1:0]        r_taps, n_taps;
    logic [POS_W-1:0]           r_fb_pos, n_fb_pos;
    logic signed [SAMPLE_W-1:0] r_amp, n_amp;
    logic signed [SAMPLE_W-1:0] r_ofs, n_ofs;

    // Stage 1: noise value and input fields
    logic                       r1_valid;
    logic [1:0]                 r1_op;
    logic signed [SAMPLE_W-1:0] r1_sample;
    logic signed [NOISE_W-1:0]  r1_noise;
    logic                       r1_bit;
    logic                       r1_last;

    // Stage 2: sum or product magnitude
    logic                       r2_valid;
    logic                       r2_is_mul;
    logic                       r2_neg;
    logic signed [SUM_W-1:0]    r2_sum;
    logic [PROD_W-1:0]          r2_prod;
    logic                       r2_bit;
    logic                       r2_last;

    // Output register
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;
    logic                       r_out_bit;
    logic                       r_out_last;

    logic load_out, load2, load1, accept;

    assign load_out   = !r_out_valid || i_m_tready;
    assign load2      = !r2_valid || load_out;
    assign load1      = !r1_valid || load2;
    assign o_s_tready = load1;
    assign accept     = i_s_tvalid && load1;

    // ---------------------------------------------------------------- config
    logic [LEN_W-1:0]    cfg_len;
    logic [MAX_BITS-1:0] cfg_mask;
    logic [MAX_BITS-1:0] cfg_state;

    always_comb begin
        cfg_len = i_cfg_data[LEN_W-1:0];
        if (cfg_len < mlsng_pkg::LEN_MIN) begin
            cfg_len = mlsng_pkg::LEN_MIN;
        end else if (cfg_len > mlsng_pkg::LEN_RESET) begin
            cfg_len = mlsng_pkg::LEN_RESET;
        end
        cfg_mask  = mlsng_pkg::width_mask(cfg_len);
        cfg_state = r_lfsr & cfg_mask;
        if (cfg_state == '0) begin
            cfg_state = cfg_mask;
        end
    end

    // ------------------------------------------------------------ LFSR step
    logic                feedback;
    logic [MAX_BITS-1:0] shifted;

    assign feedback = ^(r_lfsr & r_taps);

    always_comb begin
        shifted           = r_lfsr >> 1;
        shifted[r_fb_pos] = feedback;
        shifted           = shifted & r_mask;
    end

    always_comb begin
        n_lfsr   = r_lfsr;
        n_mask   = r_mask;
        n_taps   = r_taps;
        n_fb_pos = r_fb_pos;
        n_amp    = r_amp;
        n_ofs    = r_ofs;
        if (i_cfg_we) begin
            case (mlsng_pkg::t_cfg_reg'(i_cfg_index))
                mlsng_pkg::CFG_LENGTH: begin
                    n_lfsr   = cfg_state;
                    n_mask   = cfg_mask;
                    n_fb_pos = POS_W'(cfg_len - LEN_W'(1));
                    n_taps   = mlsng_pkg::taps_rom(POS_W'(cfg_len - LEN_W'(1)));
                end
                mlsng_pkg::CFG_AMPLITUDE: n_amp = i_cfg_data;
                mlsng_pkg::CFG_OFFSET:    n_ofs = i_cfg_data;
                default: ;
            endcase
        end else if (accept) begin
            n_lfsr = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr   <= '1;
            r_mask   <= '1;
            r_taps   <= mlsng_pkg::taps_rom(POS_W'(MAX_BITS - 1));
            r_fb_pos <= POS_W'(MAX_BITS - 1);
            r_amp    <= mlsng_pkg::AMP_RESET;
            r_ofs    <= mlsng_pkg::OFS_RESET;
        end else begin
            r_lfsr   <= n_lfsr;
            r_mask   <= n_mask;
            r_taps   <= n_taps;
            r_fb_pos <= n_fb_pos;
            r_amp    <= n_amp;
            r_ofs    <= n_ofs;
        end
    end

    // --------------------------------------------------------------- stage 1
    logic signed [NOISE_W-1:0] amp_x, ofs_x, noise;

    assign amp_x = NOISE_W'(r_amp);
    assign ofs_x = NOISE_W'(r_ofs);
    assign noise = r_lfsr[0] ? (ofs_x + amp_x) : (ofs_x - amp_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (load1) begin
            r1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_op     <= i_s_tuser;
            r1_sample <= i_s_tdata;
            r1_noise  <= noise;
            r1_bit    <= r_lfsr[0];
            r1_last   <= i_s_tlast;
        end
    end

    // --------------------------------------------------------------- stage 2
    logic signed [SUM_W-1:0] sample_x, noise_x, sum_val;
    logic [SAMPLE_W-1:0]     mag_a;
    logic [NOISE_W-1:0]      mag_b;
    logic                    is_mul;

    assign sample_x = SUM_W'(r1_sample);
    assign noise_x  = SUM_W'(r1_noise);
    assign mag_a    = r1_sample[SAMPLE_W-1] ? SAMPLE_W'(-sample_x) : SAMPLE_W'(sample_x);
    assign mag_b    = r1_noise[NOISE_W-1]   ? NOISE_W'(-noise_x)   : NOISE_W'(noise_x);

    // Operation codes outside the list act as overwrite.
    always_comb begin
        is_mul  = 1'b0;
        sum_val = noise_x;
        case (mlsng_pkg::t_op'(r1_op))
            mlsng_pkg::OP_ADD: sum_val = sample_x + noise_x;
            mlsng_pkg::OP_MUL: is_mul  = 1'b1;
            default:           sum_val = noise_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (load2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2 && r1_valid) begin
            r2_is_mul <= is_mul;
            r2_neg    <= r1_sample[SAMPLE_W-1] ^ r1_noise[NOISE_W-1];
            r2_sum    <= sum_val;
            r2_prod   <= PROD_W'(mag_a) * PROD_W'(mag_b);
            r2_bit    <= r1_bit;
            r2_last   <= r1_last;
        end
    end

    // ---------------------------------------------------------- output stage
    logic [MAG_W-1:0]    mag;
    logic [SAMPLE_W-1:0] mul_res, sum_res;

    // Round to nearest with ties away from zero, applied on the magnitude.
    assign mag = MAG_W'(({1'b0, r2_prod} + (PROD_W+1)'(1 << (mlsng_pkg::FRAC_BITS - 1)))
                        >> mlsng_pkg::FRAC_BITS);

    always_comb begin
        if (r2_neg) begin
            if (mag > MAG_W'(mlsng_pkg::SAT_MIN)) begin
                mul_res = mlsng_pkg::SAT_MIN;
            end else begin
                mul_res = SAMPLE_W'(-mag);
            end
        end else begin
            if (mag > MAG_W'(mlsng_pkg::SAT_MAX)) begin
                mul_res = mlsng_pkg::SAT_MAX;
            end else begin
                mul_res = SAMPLE_W'(mag);
            end
        end
    end

    always_comb begin
        if (r2_sum > SUM_W'($signed(mlsng_pkg::SAT_MAX))) begin
            sum_res = mlsng_pkg::SAT_MAX;
        end else if (r2_sum < SUM_W'($signed(mlsng_pkg::SAT_MIN))) begin
            sum_res = mlsng_pkg::SAT_MIN;
        end else begin
            sum_res = SAMPLE_W'(r2_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out && r2_valid) begin
            r_out_data <= r2_is_mul ? mul_res : sum_res;
            r_out_bit  <= r2_bit;
            r_out_last <= r2_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_bit;
    assign o_m_tlast  = r_out_last;

endmodule
